### hdl/mmbsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbsh_pkg
// Shared codes, constants and types for the multi-method byte string hash.
// ----------------------------------------------------------------------------
package mmbsh_pkg;

  localparam int unsigned MethodW = 4;
  localparam int unsigned HashW   = 32;
  localparam int unsigned ByteW   = 8;

  typedef logic [MethodW-1:0] method_t;
  typedef logic [HashW-1:0]   hash_t;
  typedef logic [ByteW-1:0]   byte_t;

  // method codes
  localparam method_t M_DEBUG0   = 4'd0;
  localparam method_t M_DEBUG1   = 4'd1;
  localparam method_t M_ADD      = 4'd2;
  localparam method_t M_XOR      = 4'd3;
  localparam method_t M_ROT      = 4'd4;
  localparam method_t M_BERN     = 4'd5;
  localparam method_t M_MODBERN  = 4'd6;
  localparam method_t M_SAX      = 4'd7;
  localparam method_t M_FNV      = 4'd8;
  localparam method_t M_OAT      = 4'd9;
  localparam method_t M_ELF      = 4'd10;

  localparam hash_t FNV_BASIS = 32'd2166136261;
  localparam hash_t FNV_PRIME = 32'd16777619;
  localparam hash_t BERN_MULT = 32'd33;
  localparam hash_t ELF_TOP   = 32'hF000_0000;

  // what the finishing stage needs from one completed key
  typedef struct packed {
    method_t method;
    hash_t   hash;
    byte_t   first;
    byte_t   second;
    logic    two_bytes;
  } fin_t;

endpackage

### hdl/mmbsh_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbsh_fold
// Folds one key byte into the running hash by the selected method.
// ----------------------------------------------------------------------------
module mmbsh_fold
  import mmbsh_pkg::*;
(
  input  method_t method,
  input  hash_t   hash_in,
  input  byte_t   data,
  output hash_t   hash_out
);

  hash_t b_ext;
  hash_t oat_a;
  hash_t oat_b;
  hash_t elf_t;
  hash_t elf_g;

  assign b_ext = {{(HashW-ByteW){1'b0}}, data};

  // one-at-a-time per-byte step
  assign oat_a = hash_in + b_ext;
  assign oat_b = oat_a + (oat_a << 10);

  // elf: clear top nibble after folding it back in
  assign elf_t = (hash_in << 4) + b_ext;
  assign elf_g = elf_t & ELF_TOP;

  always_comb begin
    unique case (method)
      M_ADD:     hash_out = hash_in + b_ext;
      M_XOR:     hash_out = hash_in ^ b_ext;
      M_ROT:     hash_out = (hash_in << 4) ^ (hash_in >> 28) ^ b_ext;
      M_BERN:    hash_out = (hash_in * BERN_MULT) + b_ext;
      M_MODBERN: hash_out = (hash_in * BERN_MULT) ^ b_ext;
      M_SAX:     hash_out = hash_in ^ ((hash_in << 5) + (hash_in >> 2) + b_ext);
      M_FNV:     hash_out = (hash_in * FNV_PRIME) ^ b_ext;
      M_OAT:     hash_out = oat_b ^ (oat_b >> 6);
      M_ELF:     hash_out = (elf_t ^ (elf_g >> 24)) & ~elf_g;
      default:   hash_out = hash_in;
    endcase
  end

endmodule

### hdl/mmbsh_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbsh_finish
// Final form of the hash for a completed key.
// ----------------------------------------------------------------------------
module mmbsh_finish
  import mmbsh_pkg::*;
(
  input  fin_t  fin,
  output hash_t result
);

  hash_t mix_a;
  hash_t mix_b;
  hash_t mix_c;

  // one-at-a-time final avalanche
  assign mix_a = fin.hash + (fin.hash << 3);
  assign mix_b = mix_a ^ (mix_a >> 11);
  assign mix_c = mix_b + (mix_b << 15);

  always_comb begin
    unique case (fin.method)
      M_DEBUG0: result = {fin.first, fin.first, fin.first, fin.first};
      M_DEBUG1: result = fin.two_bytes ? {fin.first, fin.first, fin.first, fin.second}
                                       : '0;
      M_OAT:    result = mix_c;
      M_ADD, M_XOR, M_ROT, M_BERN, M_MODBERN, M_SAX, M_FNV, M_ELF:
                result = fin.hash;
      default:  result = '0;
    endcase
  end

endmodule

### hdl/multi_method_byte_string_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_method_byte_string_hash_unit
// Streams key bytes and returns a 32-bit hash for each key.
//
// Usage:
//   Key bytes arrive on the input channel (key_byte, last_byte) with
//   in_valid/in_ready. One item is one byte; last_byte marks the end of a key.
//   Every key of one or more bytes yields exactly one hash_value item on the
//   out_valid/out_ready channel; bytes before the last yield nothing.
//   hash_method is written on cfg_valid/cfg_ready (cfg_ready is always high);
//   the user must write it only while the unit is idle; this is not enforced.
// Timing:
//   One byte per cycle while the output is not stalled. A byte is held in the
//   input register and then folded into the running hash; for the last byte the
//   finished key moves to the finish stage, whose final mix is registered at
//   out_valid. The running-hash feedback (fold with a 32-bit constant multiply)
//   sets the clock budget.
// Reset: rst (synchronous) empties all stages, starts a new key and selects
//   method 0.
// Stall: when out_ready is low the result holds; the stages behind it keep
//   filling and in_ready drops only once a finished key can no longer move on.
// ----------------------------------------------------------------------------
module multi_method_byte_string_hash_unit
  import mmbsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  key_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  hash_method
);

  method_t method;

  // input stage
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_last;

  // key state
  hash_t      running_hash;
  logic       at_key_start;
  byte_t      first_key_byte;
  byte_t      second_key_byte;
  logic [1:0] bytes_seen;

  // finish stage
  logic s2_valid;
  fin_t s2_fin;

  hash_t out_hash;
  logic  out_valid_q;

  logic s1_fire;
  logic s2_fire;
  logic out_free;
  logic s2_free;

  hash_t      start_hash;
  logic [1:0] seen_eff;
  byte_t      first_next;
  byte_t      second_next;
  logic [1:0] bytes_seen_next;
  hash_t      hash_next;
  hash_t      fin_hash;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid || out_ready;
  assign s2_fire  = s2_valid && out_free;
  assign s2_free  = !s2_valid || out_free;
  assign s1_fire  = s1_valid && (!s1_last || s2_free);
  assign in_ready = !s1_valid || s1_fire;

  // a new key starts from the method's seed
  assign start_hash = at_key_start ? ((method == M_FNV) ? FNV_BASIS : '0) : running_hash;
  assign seen_eff   = at_key_start ? 2'd0 : bytes_seen;

  always_comb begin
    first_next      = at_key_start ? '0 : first_key_byte;
    second_next     = at_key_start ? '0 : second_key_byte;
    bytes_seen_next = seen_eff;
    unique case (seen_eff)
      2'd0: begin
        first_next      = s1_byte;
        bytes_seen_next = 2'd1;
      end
      2'd1: begin
        second_next     = s1_byte;
        bytes_seen_next = 2'd2;
      end
      default: begin
        bytes_seen_next = seen_eff;
      end
    endcase
  end

  mmbsh_fold u_fold (
    .method   (method),
    .hash_in  (start_hash),
    .data     (s1_byte),
    .hash_out (hash_next)
  );

  mmbsh_finish u_finish (
    .fin    (s2_fin),
    .result (fin_hash)
  );

  assign out_valid  = out_valid_q;
  assign hash_value = out_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      method          <= M_DEBUG0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid_q     <= 1'b0;
      running_hash    <= '0;
      at_key_start    <= 1'b1;
      first_key_byte  <= '0;
      second_key_byte <= '0;
      bytes_seen      <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        method <= hash_method;
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        running_hash    <= hash_next;
        at_key_start    <= s1_last;
        first_key_byte  <= first_next;
        second_key_byte <= second_next;
        bytes_seen      <= bytes_seen_next;
      end
      if (s1_fire && s1_last) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= key_byte;
      s1_last <= last_byte;
    end
    if (s1_fire && s1_last) begin
      s2_fin.method    <= method;
      s2_fin.hash      <= hash_next;
      s2_fin.first     <= first_next;
      s2_fin.second    <= second_next;
      s2_fin.two_bytes <= (bytes_seen_next == 2'd2);
    end
    if (s2_fire) begin
      out_hash <= fin_hash;
    end
  end

  // bytes_seen saturates at two
  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    bytes_seen != 2'd3)
    else $error("bytes_seen out of range");

  // reset leaves every stage empty at a key boundary
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (at_key_start && !s1_valid && !s2_valid && !out_valid_q))
    else $error("stages not empty after reset");

  // a last byte hands its key to the finish stage and reopens a key
  a_last_hands_off: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (at_key_start && s2_valid))
    else $error("last byte did not complete the key");

  // a middle byte keeps the key open
  a_mid_keeps_open: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_last) |=> !at_key_start)
    else $error("key closed on a middle byte");

  // input only stalls behind a held byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_last && s2_valid && out_valid_q && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule
